// ===== design/crt_three_congruence_solver_unit_assert.svh =====
// Assertion helpers used by the checker file.
`ifndef CRT_THREE_CONGRUENCE_SOLVER_UNIT_ASSERT_SVH
`define CRT_THREE_CONGRUENCE_SOLVER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CRT3_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CRT3_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/crt3_pkg.sv =====
`default_nettype none

package crt3_pkg;

  localparam int NUM_CONGRUENCES = 3;
  localparam int MOD_W           = 10;
  localparam int DAY_W           = 30;
  localparam int IDX_W           = $clog2(NUM_CONGRUENCES);
  localparam int CNT_W           = $clog2(NUM_CONGRUENCES + 1);
  localparam int S_W             = MOD_W + 2;
  localparam int PROD_W          = DAY_W + MOD_W;

  localparam logic [DAY_W-1:0] DAY_MASK = {DAY_W{1'b1}};

  typedef struct packed {
    logic [MOD_W-1:0] residue_first;
    logic [MOD_W-1:0] residue_second;
    logic [MOD_W-1:0] residue_third;
    logic [DAY_W-1:0] start_day;
  } crt3_in_t;

  typedef struct packed {
    logic [DAY_W-1:0] days_until;
    logic             solvable;
  } crt3_out_t;

  // Datapath operations
  typedef logic [4:0] crt3_op_t;
  localparam crt3_op_t OP_NONE  = 5'd0;
  localparam crt3_op_t OP_LOAD  = 5'd1;
  localparam crt3_op_t OP_B0    = 5'd2;
  localparam crt3_op_t OP_LDM   = 5'd3;
  localparam crt3_op_t OP_R     = 5'd4;
  localparam crt3_op_t OP_GCD   = 5'd5;
  localparam crt3_op_t OP_BM    = 5'd6;
  localparam crt3_op_t OP_DG    = 5'd7;
  localparam crt3_op_t OP_MG    = 5'd8;
  localparam crt3_op_t OP_BIGMG = 5'd9;
  localparam crt3_op_t OP_A     = 5'd10;
  localparam crt3_op_t OP_EUC   = 5'd11;
  localparam crt3_op_t OP_INV   = 5'd12;
  localparam crt3_op_t OP_X     = 5'd13;
  localparam crt3_op_t OP_UPD   = 5'd14;
  localparam crt3_op_t OP_D     = 5'd15;
  localparam crt3_op_t OP_FIN   = 5'd16;

  typedef struct packed {
    logic     exec;    // execute a non-divider operation
    logic     div_go;  // launch the divider with this operation's operands
    crt3_op_t op;
  } crt3_cmd_t;

  typedef struct packed {
    logic div_done;
    logic gcd_zero;
    logic euc_zero;
    logic fail;
    logic merged;
  } crt3_status_t;

  function automatic logic [MOD_W-1:0] mod_reset(input logic [IDX_W-1:0] idx);
    logic [MOD_W-1:0] v;
    case (idx)
      IDX_W'(0): v = MOD_W'(23);
      IDX_W'(1): v = MOD_W'(28);
      IDX_W'(2): v = MOD_W'(33);
      default:   v = MOD_W'(1);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/crt3_div.sv =====
`default_nettype none

module crt3_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [crt3_pkg::DAY_W-1:0] dividend_i,
  input  wire logic [crt3_pkg::DAY_W-1:0] divisor_i,
  output logic                           done_o,
  output logic [crt3_pkg::DAY_W-1:0]     quot_o,
  output logic [crt3_pkg::DAY_W-1:0]     rem_o
);
  import crt3_pkg::*;

  localparam int STEPS = DAY_W / 2;
  localparam int SC_W  = $clog2(STEPS);

  logic [DAY_W-1:0] dvd_q, dvd_d, dvs_q, rem_q, rem_d;
  logic [SC_W-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d, done_q, done_d;
  logic [DAY_W:0]   t1, t1s, t2, t2s;
  logic             b1, b2;

  // two restoring steps per cycle
  always_comb begin
    t1 = {rem_q, dvd_q[DAY_W-1]};
    b1 = (t1 >= {1'b0, dvs_q});
    t1s = b1 ? (t1 - {1'b0, dvs_q}) : t1;
    t2 = {t1s[DAY_W-1:0], dvd_q[DAY_W-2]};
    b2 = (t2 >= {1'b0, dvs_q});
    t2s = b2 ? (t2 - {1'b0, dvs_q}) : t2;
  end

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      cnt_d = SC_W'(STEPS - 1);
      run_d = 1'b1;
    end else if (run_q) begin
      dvd_d = {dvd_q[DAY_W-3:0], b1, b2};
      rem_d = t2s[DAY_W-1:0];
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - SC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== design/crt3_dp.sv =====
`default_nettype none

module crt3_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [crt3_pkg::IDX_W-1:0]   cfg_idx_i,
  input  wire logic [crt3_pkg::MOD_W-1:0]   cfg_data_i,
  input  wire crt3_pkg::crt3_in_t           in_i,
  input  wire crt3_pkg::crt3_cmd_t          cmd_i,
  output crt3_pkg::crt3_status_t            status_o,
  output logic                              done_o,
  output crt3_pkg::crt3_out_t               res_o
);
  import crt3_pkg::*;

  logic [MOD_W-1:0] mod_q [NUM_CONGRUENCES];
  crt3_in_t         in_q;
  logic [CNT_W-1:0] idx_q;
  logic             fail_q;
  logic [DAY_W-1:0] big_m_q, b_q, ga_q, gb_q, bigmg_q, d_q;
  logic [MOD_W-1:0] m_q, r_q, diff_q, qd_q, g_q, mg_q, r0_q, r1_q, x_q, inv_q;
  logic signed [S_W-1:0] s0_q, s1_q;
  logic             done_q;
  crt3_out_t        res_q;

  logic [DAY_W-1:0] dvd, dvs, quot, rem;
  logic             div_done;

  logic [MOD_W-1:0]  cur_mod, cur_res;
  logic [MOD_W:0]    diff_sum;
  logic signed [2*S_W-2:0] qs, s_new;
  logic signed [S_W-1:0]   inv_s;
  logic [2*MOD_W-1:0] inv_qd;
  logic [PROD_W-1:0]  mx, new_b, new_m;
  logic [DAY_W:0]     tdiff;
  logic [DAY_W-1:0]   t_wrap, t_fin;

  always_comb begin
    cur_mod = mod_q[idx_q[IDX_W-1:0]];
    if (cur_mod == '0) cur_mod = MOD_W'(1);
    case (idx_q)
      CNT_W'(0): cur_res = in_q.residue_first;
      CNT_W'(1): cur_res = in_q.residue_second;
      default:   cur_res = in_q.residue_third;
    endcase
  end

  always_comb begin
    inv_qd = inv_q * qd_q;
    case (cmd_i.op)
      OP_B0:    begin dvd = DAY_W'(in_q.residue_first); dvs = big_m_q; end
      OP_R:     begin dvd = DAY_W'(cur_res);            dvs = DAY_W'(m_q); end
      OP_GCD:   begin dvd = ga_q;                       dvs = gb_q; end
      OP_BM:    begin dvd = b_q;                        dvs = DAY_W'(m_q); end
      OP_DG:    begin dvd = DAY_W'(diff_q);             dvs = DAY_W'(g_q); end
      OP_MG:    begin dvd = DAY_W'(m_q);                dvs = DAY_W'(g_q); end
      OP_BIGMG: begin dvd = big_m_q;                    dvs = DAY_W'(g_q); end
      OP_A:     begin dvd = bigmg_q;                    dvs = DAY_W'(mg_q); end
      OP_EUC:   begin dvd = DAY_W'(r0_q);               dvs = DAY_W'(r1_q); end
      OP_X:     begin dvd = DAY_W'(inv_qd);             dvs = DAY_W'(mg_q); end
      OP_D:     begin dvd = in_q.start_day;             dvs = big_m_q; end
      default:  begin dvd = '0;                         dvs = DAY_W'(1); end
    endcase
  end

  crt3_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_comb begin
    diff_sum = {1'b0, r_q} + {1'b0, m_q} - {1'b0, rem[MOD_W-1:0]};
    if (diff_sum >= {1'b0, m_q}) diff_sum = diff_sum - {1'b0, m_q};
    qs    = $signed({1'b0, quot[MOD_W-1:0]}) * s1_q;
    s_new = (2*S_W-1)'(s0_q) - qs;
    inv_s = s0_q[S_W-1] ? (s0_q + $signed({2'b00, mg_q})) : s0_q;
    mx    = big_m_q * x_q;
    new_b = PROD_W'(b_q) + mx;
    new_m = bigmg_q * m_q;
    tdiff = {1'b0, b_q} - {1'b0, d_q};
    t_wrap = tdiff[DAY_W] ? (tdiff[DAY_W-1:0] + big_m_q) : tdiff[DAY_W-1:0];
    t_fin  = (t_wrap == '0) ? big_m_q : t_wrap;
  end

  // configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CONGRUENCES; i++) mod_q[i] <= mod_reset(IDX_W'(i));
      idx_q  <= '0;
      fail_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (cfg_we_i && (CNT_W'(cfg_idx_i) < CNT_W'(NUM_CONGRUENCES))) begin
        mod_q[cfg_idx_i] <= cfg_data_i;
      end
      done_q <= cmd_i.exec && (cmd_i.op == OP_FIN);
      if (cmd_i.exec && cmd_i.op == OP_LOAD) begin
        idx_q  <= CNT_W'(1);
        fail_q <= 1'b0;
      end
      if (cmd_i.exec && cmd_i.op == OP_UPD) begin
        idx_q <= idx_q + CNT_W'(1);
        if (new_m > PROD_W'(DAY_MASK)) fail_q <= 1'b1;
      end
      if (div_done && cmd_i.op == OP_DG && rem != '0) fail_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      case (cmd_i.op)
        OP_LOAD: begin
          in_q    <= in_i;
          big_m_q <= (mod_q[0] == '0) ? DAY_W'(1) : DAY_W'(mod_q[0]);
        end
        OP_LDM: begin
          m_q  <= cur_mod;
          ga_q <= big_m_q;
          gb_q <= DAY_W'(cur_mod);
        end
        OP_INV: inv_q <= inv_s[MOD_W-1:0];
        OP_UPD: begin
          b_q     <= new_b[DAY_W-1:0];
          big_m_q <= new_m[DAY_W-1:0];
        end
        OP_FIN: begin
          res_q.days_until <= fail_q ? '0 : t_fin;
          res_q.solvable   <= !fail_q;
        end
        default: ;
      endcase
    end
    if (div_done) begin
      case (cmd_i.op)
        OP_B0:  b_q <= rem;
        OP_R:   r_q <= rem[MOD_W-1:0];
        OP_GCD: begin
          ga_q <= gb_q;
          gb_q <= rem;
        end
        OP_BM: begin
          diff_q <= diff_sum[MOD_W-1:0];
          g_q    <= ga_q[MOD_W-1:0];
        end
        OP_DG:    qd_q    <= quot[MOD_W-1:0];
        OP_MG:    mg_q    <= quot[MOD_W-1:0];
        OP_BIGMG: bigmg_q <= quot;
        OP_A: begin
          r0_q <= rem[MOD_W-1:0];
          r1_q <= mg_q;
          s0_q <= S_W'(1);
          s1_q <= '0;
        end
        OP_EUC: begin
          r0_q <= r1_q;
          r1_q <= rem[MOD_W-1:0];
          s0_q <= s1_q;
          s1_q <= s_new[S_W-1:0];
        end
        OP_X:   x_q <= rem[MOD_W-1:0];
        OP_D:   d_q <= rem;
        default: ;
      endcase
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.gcd_zero = (gb_q == '0);
  assign status_o.euc_zero = (r1_q == '0);
  assign status_o.fail     = fail_q;
  assign status_o.merged   = (idx_q == CNT_W'(NUM_CONGRUENCES));
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ===== design/crt3_ctrl.sv =====
`default_nettype none

module crt3_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire crt3_pkg::crt3_status_t status_i,
  output logic                       busy_o,
  output crt3_pkg::crt3_cmd_t        cmd_o
);
  import crt3_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_B0    = 5'd1;
  localparam logic [4:0] S_CHK   = 5'd2;
  localparam logic [4:0] S_LDM   = 5'd3;
  localparam logic [4:0] S_R     = 5'd4;
  localparam logic [4:0] S_GCD   = 5'd5;
  localparam logic [4:0] S_GCDT  = 5'd6;
  localparam logic [4:0] S_BM    = 5'd7;
  localparam logic [4:0] S_DG    = 5'd8;
  localparam logic [4:0] S_DGT   = 5'd9;
  localparam logic [4:0] S_MG    = 5'd10;
  localparam logic [4:0] S_BIGMG = 5'd11;
  localparam logic [4:0] S_A     = 5'd12;
  localparam logic [4:0] S_EUC   = 5'd13;
  localparam logic [4:0] S_EUCT  = 5'd14;
  localparam logic [4:0] S_INV   = 5'd15;
  localparam logic [4:0] S_X     = 5'd16;
  localparam logic [4:0] S_UPD   = 5'd17;
  localparam logic [4:0] S_D     = 5'd18;
  localparam logic [4:0] S_FIN   = 5'd19;

  logic [4:0] state_q, state_d, div_next;
  logic       wait_q, wait_d, is_div;
  crt3_op_t   op_sel;

  always_comb begin
    is_div   = 1'b1;
    op_sel   = OP_NONE;
    div_next = S_IDLE;
    case (state_q)
      S_B0:    begin op_sel = OP_B0;    div_next = S_CHK;   end
      S_R:     begin op_sel = OP_R;     div_next = S_GCD;   end
      S_GCD:   begin op_sel = OP_GCD;   div_next = S_GCDT;  end
      S_BM:    begin op_sel = OP_BM;    div_next = S_DG;    end
      S_DG:    begin op_sel = OP_DG;    div_next = S_DGT;   end
      S_MG:    begin op_sel = OP_MG;    div_next = S_BIGMG; end
      S_BIGMG: begin op_sel = OP_BIGMG; div_next = S_A;     end
      S_A:     begin op_sel = OP_A;     div_next = S_EUC;   end
      S_EUC:   begin op_sel = OP_EUC;   div_next = S_EUCT;  end
      S_X:     begin op_sel = OP_X;     div_next = S_UPD;   end
      S_D:     begin op_sel = OP_D;     div_next = S_FIN;   end
      S_IDLE:  begin op_sel = OP_LOAD;  is_div = 1'b0;      end
      S_LDM:   begin op_sel = OP_LDM;   is_div = 1'b0;      end
      S_INV:   begin op_sel = OP_INV;   is_div = 1'b0;      end
      S_UPD:   begin op_sel = OP_UPD;   is_div = 1'b0;      end
      S_FIN:   begin op_sel = OP_FIN;   is_div = 1'b0;      end
      default: is_div = 1'b0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    wait_d       = wait_q;
    cmd_o.op     = op_sel;
    cmd_o.exec   = 1'b0;
    cmd_o.div_go = 1'b0;
    if (is_div) begin
      if (!wait_q) begin
        cmd_o.div_go = 1'b1;
        wait_d       = 1'b1;
      end else if (status_i.div_done) begin
        wait_d  = 1'b0;
        state_d = div_next;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cmd_o.exec = 1'b1;
            state_d    = S_B0;
          end
        end
        S_CHK: begin
          if (status_i.fail)        state_d = S_FIN;
          else if (status_i.merged) state_d = S_D;
          else                      state_d = S_LDM;
        end
        S_GCDT:  state_d = status_i.gcd_zero ? S_BM : S_GCD;
        S_DGT:   state_d = status_i.fail ? S_FIN : S_MG;
        S_EUCT:  state_d = status_i.euc_zero ? S_INV : S_EUC;
        S_LDM:   begin cmd_o.exec = 1'b1; state_d = S_R;    end
        S_INV:   begin cmd_o.exec = 1'b1; state_d = S_X;    end
        S_UPD:   begin cmd_o.exec = 1'b1; state_d = S_CHK;  end
        S_FIN:   begin cmd_o.exec = 1'b1; state_d = S_IDLE; end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== design/crt_three_congruence_solver_unit.sv =====
// channel   direction  handshake                 payload
// input     in         start_i / busy_o          in_i (crt3_in_t)
// result    out        done_o strobe             res_o (crt3_out_t)
// config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A transaction is taken when start_i is high and busy_o is low.
// All divisions share one divider retiring two quotient bits per cycle;
// a query ends early when a merge fails; otherwise its run time is set by
// its gcd and Euclid iterations.
// The result shows on res_o with a one-cycle done_o strobe and stays there;
// the receiver cannot stall it; a new transaction may start in that cycle.
// Reset loads the moduli 23, 28 and 33; no clearing pass is needed.
`default_nettype none

module crt_three_congruence_solver_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [crt3_pkg::IDX_W-1:0] cfg_idx_i,
  input  wire logic [crt3_pkg::MOD_W-1:0] cfg_data_i,
  input  wire logic                       start_i,
  input  wire crt3_pkg::crt3_in_t         in_i,
  output logic                            busy_o,
  output logic                            done_o,
  output crt3_pkg::crt3_out_t             res_o
);
  import crt3_pkg::*;

  crt3_cmd_t    cmd;
  crt3_status_t status;

  crt3_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .busy_o   (busy_o),
    .cmd_o    (cmd)
  );

  crt3_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .done_o     (done_o),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

// ===== design/crt3_checker.sv =====
`default_nettype none
`include "crt_three_congruence_solver_unit_assert.svh"

module crt3_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start_i,
  input wire logic                       busy_o,
  input wire logic                       done_o,
  input wire crt3_pkg::crt3_out_t        res_o
);
  import crt3_pkg::*;

  `CRT3_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o, "no busy after accept")
  `CRT3_ASSERT_SAME(a_fail_zero, clk_i, rst_ni, done_o && !res_o.solvable, res_o.days_until == '0, "unsolvable result not zero")
  `CRT3_ASSERT_SAME(a_ok_nonzero, clk_i, rst_ni, done_o && res_o.solvable, res_o.days_until != '0, "solvable result is zero")
  `CRT3_ASSERT_SAME(a_end_done, clk_i, rst_ni, $fell(busy_o), done_o, "transaction ended without result")
  `CRT3_ASSERT_NEXT(a_one_result, clk_i, rst_ni, done_o, !done_o, "result repeated")

endmodule

bind crt_three_congruence_solver_unit crt3_checker u_crt3_checker (.*);

`default_nettype wire

// ===== test/crt_three_congruence_solver_unit_tb.sv =====
`timescale 1ns / 1ps

module crt_three_congruence_solver_unit_tb;
  import crt3_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 1000;
  localparam logic [IDX_W-1:0] REG_MOD_FIRST  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_MOD_SECOND = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_MOD_THIRD  = IDX_W'(2);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [MOD_W-1:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  crt3_in_t in_i = '0;
  logic busy_o;
  logic done_o;
  crt3_out_t res_o;

  crt_three_congruence_solver_unit dut (.*);

  always #5 clk_i = ~clk_i;

  logic [MOD_W-1:0] moduli [3];
  crt3_in_t pending_queries [$];
  crt3_out_t expected_answers [$];
  int unsigned send_idle_pct = 0;
  bit hold_sender = 1'b0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic longint unsigned inv_mod(longint unsigned a, longint unsigned n);
    longint r0, r1, s0, s1, q, t;
    if (n == 1) return 0;
    r0 = longint'(a % n);
    r1 = longint'(n);
    s0 = 1;
    s1 = 0;
    while (r1 != 0) begin
      q = r0 / r1;
      t = r0 - q * r1; r0 = r1; r1 = t;
      t = s0 - q * s1; s0 = s1; s1 = t;
    end
    s0 = s0 % longint'(n);
    if (s0 < 0) s0 += longint'(n);
    return longint'(s0);
  endfunction

  function automatic crt3_out_t solve_congruences(crt3_in_t q);
    crt3_out_t o;
    longint unsigned b, big_m, m, r, g, diff, mg, x, d, t;
    logic [MOD_W-1:0] res [3];
    res[0] = q.residue_first;
    res[1] = q.residue_second;
    res[2] = q.residue_third;
    o = '0;
    big_m = (moduli[0] == 0) ? 1 : moduli[0];
    b = res[0] % big_m;
    for (int i = 1; i < 3; i++) begin
      m = (moduli[i] == 0) ? 1 : moduli[i];
      r = res[i] % m;
      g = gcd64(big_m, m);
      diff = (r + m - (b % m)) % m;
      if (diff % g != 0) return o;
      mg = m / g;
      x = (inv_mod((big_m / g) % mg, mg) * (diff / g)) % mg;
      b = b + big_m * x;
      big_m = (big_m / g) * m;
      if (big_m > DAY_MASK) return o;
      b = b % big_m;
    end
    d = q.start_day % big_m;
    t = (b + big_m - d) % big_m;
    if (t == 0) t = big_m;
    o.days_until = DAY_W'(t);
    o.solvable = 1'b1;
    return o;
  endfunction

  // driver: one transaction at a time, predicted when accepted
  always @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      expected_answers.push_back(solve_congruences(in_i));
      void'(pending_queries.pop_front());
    end
    if (pending_queries.size() > 0 && !hold_sender &&
        $urandom_range(99, 0) >= send_idle_pct) begin
      start_i <= 1'b1;
      in_i <= pending_queries[0];
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    crt3_out_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp_r = expected_answers.pop_front();
        if (res_o.days_until !== exp_r.days_until)
          report_mismatch($sformatf("days_until %0d expected %0d",
                                    res_o.days_until, exp_r.days_until));
        if (res_o.solvable !== exp_r.solvable)
          report_mismatch($sformatf("solvable %0b expected %0b",
                                    res_o.solvable, exp_r.solvable));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // hold the write enable across back-to-back writes; the caller drops it
  task automatic write_modulus(input logic [IDX_W-1:0] idx, input logic [MOD_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    moduli[idx] = val;
  endtask

  task automatic set_moduli(input logic [MOD_W-1:0] a, b, c);
    write_modulus(REG_MOD_FIRST, a);
    write_modulus(REG_MOD_SECOND, b);
    write_modulus(REG_MOD_THIRD, c);
    cfg_we_i <= 1'b0;
  endtask

  // wait for every transaction to leave and the block to go idle
  task automatic drain();
    while (pending_queries.size() > 0 || expected_answers.size() > 0 || start_i || busy_o)
      @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic crt3_in_t make_query(input logic [MOD_W-1:0] a, b, c,
                                          input logic [DAY_W-1:0] day);
    crt3_in_t q;
    q.residue_first = a;
    q.residue_second = b;
    q.residue_third = c;
    q.start_day = day;
    return q;
  endfunction

  // mostly reduced residues, sometimes full-range ones
  function automatic logic [MOD_W-1:0] pick_residue(logic [MOD_W-1:0] m);
    if (m != 0 && $urandom_range(3, 0) != 0) return MOD_W'($urandom_range(m - 1, 0));
    return MOD_W'($urandom());
  endfunction

  // usually a consistent system by reducing one common solution, else random residues
  function automatic crt3_in_t random_query();
    logic [DAY_W-1:0] day, sol;
    day = ($urandom_range(3, 0) == 0) ? DAY_MASK - DAY_W'($urandom_range(50, 0))
                                     : DAY_W'($urandom());
    if ($urandom_range(2, 0) != 0) begin
      sol = DAY_W'($urandom());
      return make_query(MOD_W'(sol % ((moduli[0] == 0) ? 1 : moduli[0])),
                        MOD_W'(sol % ((moduli[1] == 0) ? 1 : moduli[1])),
                        MOD_W'(sol % ((moduli[2] == 0) ? 1 : moduli[2])), day);
    end
    return make_query(pick_residue(moduli[0]), pick_residue(moduli[1]),
                      pick_residue(moduli[2]), day);
  endfunction

  task automatic random_phase(input int unsigned count);
    for (int i = 0; i < count; i++) pending_queries.push_back(random_query());
    drain();
  endtask

  initial begin
    moduli[0] = 23;
    moduli[1] = 28;
    moduli[2] = 33;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed at reset moduli: extremes, start-day solution, unreduced residues
    pending_queries.push_back(make_query('0, '0, '0, '0));
    pending_queries.push_back(make_query('1, '1, '1, DAY_MASK));
    pending_queries.push_back(make_query(10'd5, 10'd5, 10'd5, 30'd5));
    pending_queries.push_back(make_query(10'd22, 10'd27, 10'd32, 30'd21251));
    pending_queries.push_back(make_query(10'd1000, 10'd999, 10'd998, 30'd12345));
    drain();
    set_moduli(10'd0, 10'd0, 10'd0);
    pending_queries.push_back(make_query('1, 10'd7, '0, 30'd17));
    drain();
    set_moduli(10'd1023, 10'd1022, 10'd1021);
    pending_queries.push_back(make_query('1, 10'd1021, 10'd1020, DAY_MASK));
    pending_queries.push_back(make_query(10'd1022, 10'd1021, 10'd1020, 30'd0));
    drain();
    set_moduli(10'd12, 10'd18, 10'd30);
    pending_queries.push_back(make_query(10'd5, 10'd11, 10'd29, 30'd100));
    pending_queries.push_back(make_query(10'd5, 10'd12, 10'd29, 30'd100));
    pending_queries.push_back(make_query(10'd5, 10'd11, 10'd28, 30'd41));
    drain();
    set_moduli(10'd1023, 10'd1023, 10'd1);
    pending_queries.push_back(make_query(10'd300, 10'd300, 10'd0, 30'd300));
    pending_queries.push_back(make_query(10'd300, 10'd301, 10'd0, 30'd300));
    drain();

    // random phases under changing moduli and idle settings
    for (int p = 0; p < 19; p++) begin
      send_idle_pct = (p < 6) ? 20 : (p < 12) ? 73 : 0;
      case (p % 4)
        0: set_moduli(MOD_W'($urandom_range(1023, 1)), MOD_W'($urandom_range(1023, 1)),
                      MOD_W'($urandom_range(1023, 1)));
        1: set_moduli(MOD_W'($urandom_range(40, 1) * 6), MOD_W'($urandom_range(40, 1) * 4),
                      MOD_W'($urandom_range(40, 1) * 10));
        2: set_moduli(MOD_W'($urandom_range(30, 0)), MOD_W'($urandom_range(30, 0)),
                      MOD_W'($urandom_range(1023, 990)));
        default: set_moduli(MOD_W'($urandom_range(1023, 1000)),
                            MOD_W'($urandom_range(1023, 1000)), MOD_W'($urandom()));
      endcase
      random_phase(50);
      // pause until the block has answered everything
      hold_sender = 1'b1;
      random_phase(0);
      for (int i = 0; i < 5; i++) pending_queries.push_back(random_query());
      hold_sender = 1'b0;
      random_phase(45);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
